// ===== design/lrpc_pkg.sv =====
package lrpc_pkg;

  localparam int unsigned SIN_A = 102944;
  localparam int unsigned SIN_B = 42048;
  localparam int unsigned SIN_C = 4640;

  localparam logic [2:0] REG_COLUMNS   = 3'd0;
  localparam logic [2:0] REG_ROWS      = 3'd1;
  localparam logic [2:0] REG_AZ_START  = 3'd2;
  localparam logic [2:0] REG_AZ_STEP   = 3'd3;
  localparam logic [2:0] REG_EL_START  = 3'd4;
  localparam logic [2:0] REG_EL_STEP   = 3'd5;
  localparam logic [2:0] REG_RANGE_LO  = 3'd6;
  localparam logic [2:0] REG_RANGE_HI  = 3'd7;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Per-ray control carried along the chain.
  typedef struct packed {
    logic planar;
    logic in_lim;
    logic last;
  } ray_ctl_t;

endpackage

// ===== design/lrpc_if.sv =====
interface lrpc_in_if #(parameter int RANGE_BITS = 24);
  logic                  valid;
  logic                  ready;
  logic [RANGE_BITS-1:0] distance;
  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

interface lrpc_out_if #(parameter int RANGE_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [RANGE_BITS:0]   point_x;
  logic signed [RANGE_BITS:0]   point_y;
  logic signed [RANGE_BITS:0]   point_z;
  logic                         valid_res;
  logic [RANGE_BITS-1:0]        raw_range;
  logic                         last;
  modport source (output valid, output point_x, output point_y, output point_z,
                  output valid_res, output raw_range, output last, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input valid_res, input raw_range, input last, output ready);
endinterface

// ===== design/lrpc_cell.sv =====
// One stage of the side-band chain: valid, ray control, distance and signs.
// Each cell registers its inputs; enable advances the whole chain.
module lrpc_cell #(
  parameter int RANGE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_in,
  input  lrpc_pkg::ray_ctl_t    ctl_in,
  input  logic [RANGE_BITS-1:0] d_in,
  input  logic [3:0]            sg_in,
  output logic                  vld_out,
  output lrpc_pkg::ray_ctl_t    ctl_out,
  output logic [RANGE_BITS-1:0] d_out,
  output logic [3:0]            sg_out
);
  logic                  vld_r;
  lrpc_pkg::ray_ctl_t    ctl_r;
  logic [RANGE_BITS-1:0] d_r;
  logic [3:0]            sg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_in;
      d_r   <= d_in;
      sg_r  <= sg_in;
    end
  end

  assign vld_out = vld_r;
  assign ctl_out = ctl_r;
  assign d_out   = d_r;
  assign sg_out  = sg_r;
endmodule

// ===== design/lrpc_sine.sv =====
// Quarter-wave sine polynomial as a chain of four multiply cells.
module lrpc_sine (
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] u_in,
  output logic [16:0] s_out
);
  logic [16:0] u1_r, u2_r, u3_r;
  logic [16:0] q1_r, q2_r;
  logic [16:0] t_r;
  logic [16:0] r_r;
  logic [16:0] s_r;
  logic [33:0] m0, m1, m2, m3;
  logic [16:0] inner;
  logic [16:0] rr;

  assign m0 = u_in * u_in;
  assign m1 = 34'(lrpc_pkg::SIN_C) * {17'd0, q1_r};
  assign inner = 17'(lrpc_pkg::SIN_B - 32'(m1[33:16]));
  assign m2 = {17'd0, t_r} * {17'd0, q2_r};
  assign rr = 17'(lrpc_pkg::SIN_A - 32'(m2[33:16]));
  assign m3 = {17'd0, r_r} * {17'd0, u3_r};

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r <= u_in;
      q1_r <= m0[32:16];
      u2_r <= u1_r;
      q2_r <= q1_r;
      t_r  <= inner;
      u3_r <= u2_r;
      r_r  <= rr;
      s_r  <= m3[32:16];
    end
  end

  assign s_out = s_r;
endmodule

// ===== design/lidar_range_to_point_cloud.sv =====
// Throughput: one ray per cycle; the chain of multiply cells advances
// whenever the output register is free or being drained.
// Reset (rst_n, synchronous): registers to their reset values, counters 0,
// angles to the start values, chain emptied.
module lidar_range_to_point_cloud #(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 1024,
  parameter int RANGE_BITS  = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                            cfg_we,
  input  logic [lrpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrpc_pkg::CFG_DATA_W-1:0] cfg_data,
  lrpc_in_if.sink    in_ch,
  lrpc_out_if.source out_ch
);
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int L  = 6;

  logic [12:0] columns_r;
  logic [10:0] rows_r;
  logic [31:0] az_start_r, az_step_r, el_start_r, el_step_r;
  logic [23:0] rlo_r, rhi_r;
  logic [CW-1:0] ccnt_r;
  logic [RW-1:0] rcnt_r;
  logic [31:0] az_r, el_r;

  logic en, take;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign take = in_ch.valid && en;

  logic [CW-1:0] ncol;
  logic [RW-1:0] nrow;
  always_comb begin
    if (columns_r == 13'd0) ncol = CW'(1);
    else if (32'(columns_r) > MAX_COLUMNS) ncol = CW'(MAX_COLUMNS);
    else ncol = CW'(columns_r);
    if (rows_r == 11'd0) nrow = RW'(1);
    else if (32'(rows_r) > MAX_ROWS) nrow = RW'(MAX_ROWS);
    else nrow = RW'(rows_r);
  end

  logic col_end, row_end;
  assign col_end = (32'(ccnt_r) + 32'd1) >= 32'(ncol);
  assign row_end = (32'(rcnt_r) + 32'd1) >= 32'(nrow);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= 13'd1024; rows_r <= 11'd16;
      az_start_r <= '0; az_step_r <= 32'd4194304;
      el_start_r <= '0; el_step_r <= '0;
      rlo_r <= '0; rhi_r <= 24'd1024000;
      ccnt_r <= '0; rcnt_r <= '0; az_r <= '0; el_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          4'(lrpc_pkg::REG_COLUMNS):  columns_r <= cfg_data[12:0];
          4'(lrpc_pkg::REG_ROWS):     rows_r <= cfg_data[10:0];
          4'(lrpc_pkg::REG_AZ_START): begin
            az_start_r <= cfg_data;
            if (ccnt_r == '0) az_r <= cfg_data;
          end
          4'(lrpc_pkg::REG_AZ_STEP):  az_step_r <= cfg_data;
          4'(lrpc_pkg::REG_EL_START): begin
            el_start_r <= cfg_data;
            if (ccnt_r == '0 && rcnt_r == '0) el_r <= cfg_data;
          end
          4'(lrpc_pkg::REG_EL_STEP):  el_step_r <= cfg_data;
          4'(lrpc_pkg::REG_RANGE_LO): rlo_r <= cfg_data[23:0];
          4'(lrpc_pkg::REG_RANGE_HI): rhi_r <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (take) begin
        if (col_end) begin
          ccnt_r <= '0;
          az_r <= az_start_r;
          if (row_end) begin
            rcnt_r <= '0;
            el_r <= el_start_r;
          end else begin
            rcnt_r <= rcnt_r + RW'(1);
            el_r <= el_r + el_step_r;
          end
        end else begin
          ccnt_r <= ccnt_r + CW'(1);
          az_r <= az_r + az_step_r;
        end
      end
    end
  end

  // Stage 0: quadrant fold for four angles.
  function automatic logic [16:0] fold(input logic [31:0] a);
    logic [16:0] f;
    f = {1'b0, a[29:14]};
    return a[30] ? 17'(17'd65536 - f) : f;
  endfunction

  logic [31:0] az_c, el_c;
  assign az_c = az_r + 32'h4000_0000;
  assign el_c = el_r + 32'h4000_0000;

  logic [RANGE_BITS-1:0] d0;
  assign d0 = in_ch.distance;

  logic                  vld_c [L+1];
  lrpc_pkg::ray_ctl_t    ctl_c [L+1];
  logic [RANGE_BITS-1:0] d_c [L+1];
  logic [3:0]            sg_c [L+1];
  logic [16:0] ca, sa, ce, se;

  assign vld_c[0] = take;
  assign ctl_c[0] = '{planar: (nrow == RW'(1)),
                      in_lim: (32'(d0) >= 32'(rlo_r)) && (32'(d0) <= 32'(rhi_r)),
                      last:   col_end && row_end};
  assign d_c[0]  = d0;
  assign sg_c[0] = {az_c[31], az_r[31], el_c[31], el_r[31]};

  for (genvar i = 0; i < L; i++) begin : g_cell
    lrpc_cell #(.RANGE_BITS(RANGE_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(vld_c[i]), .ctl_in(ctl_c[i]), .d_in(d_c[i]), .sg_in(sg_c[i]),
      .vld_out(vld_c[i+1]), .ctl_out(ctl_c[i+1]), .d_out(d_c[i+1]),
      .sg_out(sg_c[i+1])
    );
  end

  lrpc_sine u_sca (.clk(clk), .en(en), .u_in(fold(az_c)), .s_out(ca));
  lrpc_sine u_ssa (.clk(clk), .en(en), .u_in(fold(az_r)), .s_out(sa));
  lrpc_sine u_sce (.clk(clk), .en(en), .u_in(fold(el_c)), .s_out(ce));
  lrpc_sine u_sse (.clk(clk), .en(en), .u_in(fold(el_r)), .s_out(se));

  // Sines ready after the fourth stage. Stage 5: d*ce, d*se.
  logic [RANGE_BITS+16:0] dce_r, dse_r;
  logic [16:0] ca_r, sa_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dce_r <= (RANGE_BITS+17)'(d_c[4]) * (RANGE_BITS+17)'(ce);
      dse_r <= (RANGE_BITS+17)'(d_c[4]) * (RANGE_BITS+17)'(se);
      ca_r <= ca; sa_r <= sa;
    end
  end

  // Stage 6: second products and rounding.
  logic [RANGE_BITS+33:0] mxf, myf;
  logic [RANGE_BITS:0] mx_r, my_r, mz_r;
  assign mxf = (RANGE_BITS+34)'(dce_r) * (RANGE_BITS+34)'(ca_r)
             + (RANGE_BITS+34)'(64'h8000_0000);
  assign myf = (RANGE_BITS+34)'(dce_r) * (RANGE_BITS+34)'(sa_r)
             + (RANGE_BITS+34)'(64'h8000_0000);
  logic [RANGE_BITS+16:0] mzf;
  assign mzf = dse_r + (RANGE_BITS+17)'(32'h8000);
  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= mxf[RANGE_BITS+32:32];
      my_r <= myf[RANGE_BITS+32:32];
      mz_r <= mzf[RANGE_BITS+16:16];
    end
  end

  function automatic logic [RANGE_BITS:0] sgn(input logic [RANGE_BITS:0] m, input logic n);
    return n ? (RANGE_BITS+1)'(-m) : m;
  endfunction

  lrpc_pkg::ray_ctl_t c6;
  logic [3:0] s6;
  logic ok;
  assign c6 = ctl_c[L];
  assign s6 = sg_c[L];
  assign ok = !c6.planar && c6.in_lim;
  assign out_ch.valid     = vld_c[L];
  assign out_ch.point_x   = ok ? sgn(mx_r, s6[3] ^ s6[1]) : '0;
  assign out_ch.point_y   = ok ? sgn(my_r, s6[2] ^ s6[1]) : '0;
  assign out_ch.point_z   = ok ? sgn(mz_r, s6[0]) : '0;
  assign out_ch.valid_res = c6.planar || c6.in_lim;
  assign out_ch.raw_range = c6.planar ? d_c[L] : '0;
  assign out_ch.last      = c6.last;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.last))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready) else $error("ready low with empty output");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ccnt_r) < MAX_COLUMNS) else $error("column count overflow");
`endif
endmodule
